@@ hw/rtl/spt_pkg.sv @@
// spt_pkg: shared types, widths, defaults and codes for the spindle encoder tracker
// no dependencies; imported by spt_divider and spindle_encoder_tracker

package spt_pkg;

  // field and datapath widths
  localparam int POS_W      = 48;
  localparam int RPM_W      = 18;
  localparam int RAW_W      = 16;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // default encoder geometry
  localparam int COUNTS_PER_REV_DEF = 1200;
  localparam int COUNTER_WRAP_DEF   = 30000;

  // 60000 ms per minute times 16 for the 1/16 rpm unit
  localparam int RPM_SCALE   = 60000 * 16;
  localparam int RPM_MAX     = 131071;
  localparam int RPM_NEG_MAG = 131072;

  // speed divider: numerator is magnitude times RPM_SCALE, 18 quotient bits
  localparam int DIV_NUM_W = 68;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_Q_W   = RPM_W;

  // register reset values
  localparam logic [7:0]  POLL_DEF  = 8'd2;
  localparam logic [15:0] WIN_DEF   = 16'd50;
  localparam logic [15:0] STALL_DEF = 16'd100;
  localparam logic [15:0] TOL_DEF   = 16'd3;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] spt_reg_idx_t;
  localparam spt_reg_idx_t REG_DIRECTION = 3'd0;
  localparam spt_reg_idx_t REG_POLL      = 3'd1;
  localparam spt_reg_idx_t REG_WINDOW    = 3'd2;
  localparam spt_reg_idx_t REG_STALL     = 3'd3;
  localparam spt_reg_idx_t REG_REV_TOL   = 3'd4;

  // fault codes
  typedef logic [1:0] spt_fault_t;
  localparam spt_fault_t FAULT_NONE  = 2'd0;
  localparam spt_fault_t FAULT_STALL = 2'd1;
  localparam spt_fault_t FAULT_REV   = 2'd2;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } spt_div_stat_t;

endpackage

@@ hw/rtl/spt_divider.sv @@
// spt_divider: restoring divider, one quotient bit per cycle, with quotient overflow flag
// depends on spt_pkg for default widths and the status struct

module spt_divider import spt_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output spt_div_stat_t    stat
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r;
  logic             done_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quo_r;

  logic [HI_W-1:0]  hi;
  logic             hi_ovf;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_diff;
  logic             trial_ge;

  // quotient would need more than Q_W bits
  assign hi     = num[NUM_W-1:Q_W];
  assign hi_ovf = hi >= HI_W'(den);

  // one restoring step
  assign trial      = {rem_r, low_r[Q_W-1]};
  assign trial_ge   = trial >= {1'b0, den};
  assign trial_diff = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
        rem_r  <= hi[DEN_W-1:0];
        low_r  <= num[Q_W-1:0];
        ovf_r  <= hi_ovf;
      end else if (busy_r) begin
        rem_r <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_r <= {low_r[Q_W-2:0], 1'b0};
        quo_r <= {quo_r[Q_W-2:0], trial_ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

@@ hw/rtl/spindle_encoder_tracker.sv @@
// spindle_encoder_tracker: poll sequencer for position, speed and spindle fault tracking
// depends on spt_pkg and spt_divider (quotient unit for the speed computation)
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   raw_count, now_ticks, tracking_active, follow_busy,
//                                     new_sync_block
// out      out  out_valid / out_stall position_counts, rpm_x16, rpm_updated, polled,
//                                     fault_now, fault_latched
// cfg      in   cfg_we                cfg_index, cfg_wdata
//
// every poll walks the sequencer from accept to result, and the done step waits while
// out_stall holds the last result; the divider takes 18 single-bit steps for the quotient
// in_stall is high from the accept until the result is loaded into the output register
// a finished result waits in the output register while the next poll is accepted
// synchronous active-low reset returns all tracking state and registers to defaults

module spindle_encoder_tracker import spt_pkg::*; #(
  parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF, // 4 .. 65535
  parameter int COUNTER_WRAP   = COUNTER_WRAP_DEF    // 2 .. 32767
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // poll channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] in_raw_count,
  input  logic [TICK_W-1:0]       in_now_ticks,
  input  logic                    in_tracking_active,
  input  logic                    in_follow_busy,
  input  logic                    in_new_sync_block,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_position_counts,
  output logic signed [RPM_W-1:0] out_rpm_x16,
  output logic                    out_rpm_updated,
  output logic                    out_polled,
  output logic [1:0]              out_fault_now,
  output logic [1:0]              out_fault_latched,
  // register port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DELTA_W = RAW_W + 2;
  localparam logic signed [DELTA_W-1:0] WRAP_D = DELTA_W'(COUNTER_WRAP);
  localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(COUNTER_WRAP / 2);
  localparam logic [POS_W-1:0]          CPR_P  = POS_W'(COUNTS_PER_REV);
  localparam logic [DIV_NUM_W-1:0]      SCALE_N = DIV_NUM_W'(RPM_SCALE);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SUM, ST_APPLY, ST_CHECK, ST_FAULT,
    ST_DEN, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_SAT, ST_DONE
  } state_t;

  state_t state_r;

  // registers
  logic              dir_r;
  logic [7:0]        poll_r;
  logic [15:0]       win_r;
  logic [15:0]       stall_lim_r;
  logic [15:0]       tol_r;

  // tracking state
  logic              init_r;
  logic [RAW_W-1:0]  prev_r;
  logic [POS_W-1:0]  acc_r;
  logic [TICK_W-1:0] last_poll_r;
  logic [TICK_W-1:0] last_change_r;
  logic [POS_W-1:0]  sref_pos_r;
  logic [TICK_W-1:0] sref_time_r;
  logic [RPM_W-1:0]  speed_r;
  logic [POS_W-1:0]  fur_r;
  spt_fault_t        sticky_r;

  // poll beat and working values
  logic [RAW_W-1:0]     raw_r;
  logic [TICK_W-1:0]    now_r;
  logic                 trk_r;
  logic                 busy_r;
  logic                 newblk_r;
  logic [DELTA_W-1:0]   delta_r;
  logic                 poll_go_r;
  logic [POS_W-1:0]     sum_r;
  logic [TICK_W-1:0]    dt_r;
  logic [POS_W-1:0]     orient_r;
  logic                 spd_go_r;
  logic [POS_W-1:0]     diff_r;
  logic                 act_r;
  logic                 stall_hit_r;
  spt_fault_t           fault_r;
  logic [POS_W-1:0]     den_r;
  logic                 neg_r;
  logic [POS_W-1:0]     mag_r;
  logic [DIV_NUM_W-1:0] num_r;

  // output register
  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [RPM_W-1:0]  out_rpm_r;
  logic              out_upd_r;
  logic              out_polled_r;
  spt_fault_t        out_fault_r;
  spt_fault_t        out_sticky_r;

  // combinational helpers
  logic signed [DELTA_W-1:0] delta_raw;
  logic signed [DELTA_W-1:0] delta_fold;
  logic [TICK_W-1:0]         win_eff;
  logic [POS_W-1:0]          orient_nxt;
  logic signed [POS_W:0]     back_dist;
  spt_fault_t                fault_nxt;
  logic [RPM_W-1:0]          rpm_lim;
  logic [RPM_W-1:0]          rpm_mag;
  logic [RPM_W-1:0]          speed_nxt;
  logic                      div_start;
  logic [DIV_Q_W-1:0]        div_quo;
  spt_div_stat_t             div_stat;

  // wrap fold of the counter step
  always_comb begin
    delta_raw  = DELTA_W'($signed(raw_r)) - DELTA_W'($signed(prev_r));
    delta_fold = delta_raw;
    if (delta_raw > HALF_D) begin
      delta_fold = delta_raw - WRAP_D;
    end else if (delta_raw < -HALF_D) begin
      delta_fold = delta_raw + WRAP_D;
    end
  end

  // zero window counts as one tick
  assign win_eff = (win_r == 16'd0) ? TICK_W'(1) : TICK_W'(win_r);

  // position in the commanded direction
  assign orient_nxt = dir_r ? (POS_W'(0) - sum_r) : sum_r;

  // backward distance from the furthest point
  assign back_dist = {fur_r[POS_W-1], fur_r} - {orient_r[POS_W-1], orient_r};

  // stall is checked before reversal
  always_comb begin
    fault_nxt = FAULT_NONE;
    if (act_r) begin
      if (stall_hit_r) begin
        fault_nxt = FAULT_STALL;
      end else if (back_dist > $signed({{(POS_W - 15){1'b0}}, tol_r})) begin
        fault_nxt = FAULT_REV;
      end
    end
  end

  // saturate and sign the quotient
  always_comb begin
    rpm_lim = neg_r ? RPM_W'(RPM_NEG_MAG) : RPM_W'(RPM_MAX);
    rpm_mag = (div_stat.ovf || (div_quo > rpm_lim)) ? rpm_lim : div_quo;
    speed_nxt = neg_r ? (RPM_W'(0) - rpm_mag) : rpm_mag;
  end

  assign div_start = (state_r == ST_DIV_GO);

  spt_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // sequencer, tracking state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      dir_r         <= 1'b0;
      poll_r        <= POLL_DEF;
      win_r         <= WIN_DEF;
      stall_lim_r   <= STALL_DEF;
      tol_r         <= TOL_DEF;
      init_r        <= 1'b0;
      prev_r        <= '0;
      acc_r         <= '0;
      last_poll_r   <= '0;
      last_change_r <= '0;
      sref_pos_r    <= '0;
      sref_time_r   <= '0;
      speed_r       <= '0;
      fur_r         <= '0;
      sticky_r      <= FAULT_NONE;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIRECTION: dir_r       <= cfg_wdata[0];
          REG_POLL:      poll_r      <= cfg_wdata[7:0];
          REG_WINDOW:    win_r       <= cfg_wdata;
          REG_STALL:     stall_lim_r <= cfg_wdata;
          REG_REV_TOL:   tol_r       <= cfg_wdata;
          default: ;
        endcase
      end

      // result beat taken, the done step reloads the register itself
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            raw_r    <= in_raw_count;
            now_r    <= in_now_ticks;
            trk_r    <= in_tracking_active;
            busy_r   <= in_follow_busy;
            newblk_r <= in_new_sync_block;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // first poll only loads the counter
          if (!init_r) begin
            prev_r  <= raw_r;
            acc_r   <= POS_W'($signed(raw_r));
            init_r  <= 1'b1;
            delta_r <= '0;
          end else begin
            delta_r <= delta_fold;
          end
          poll_go_r <= init_r && ((now_r - last_poll_r) >= TICK_W'(poll_r));
          state_r   <= ST_SUM;
        end
        ST_SUM: begin
          sum_r   <= acc_r + POS_W'($signed(delta_r));
          dt_r    <= now_r - sref_time_r;
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          orient_r <= orient_nxt;
          if (newblk_r && trk_r) begin
            fur_r <= orient_nxt;
          end
          if (poll_go_r) begin
            acc_r       <= sum_r;
            prev_r      <= raw_r;
            last_poll_r <= now_r;
            if (delta_r != '0) begin
              last_change_r <= now_r;
            end
          end
          spd_go_r <= poll_go_r && (dt_r >= win_eff);
          diff_r   <= sum_r - sref_pos_r;
          act_r    <= poll_go_r && trk_r && !busy_r;
          state_r  <= ST_CHECK;
        end
        ST_CHECK: begin
          if (act_r && ($signed(orient_r) > $signed(fur_r))) begin
            fur_r <= orient_r;
          end
          stall_hit_r <= (now_r - last_change_r) > TICK_W'(stall_lim_r);
          state_r     <= ST_FAULT;
        end
        ST_FAULT: begin
          fault_r <= fault_nxt;
          if (fault_nxt != FAULT_NONE) begin
            sticky_r <= fault_nxt;
          end
          state_r <= ST_DEN;
        end
        ST_DEN: begin
          den_r   <= CPR_P * POS_W'(dt_r);
          neg_r   <= diff_r[POS_W-1];
          mag_r   <= diff_r[POS_W-1] ? (POS_W'(0) - diff_r) : diff_r;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          num_r   <= DIV_NUM_W'(mag_r) * SCALE_N;
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (spd_go_r) begin
            speed_r     <= speed_nxt;
            sref_pos_r  <= acc_r;
            sref_time_r <= now_r;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_pos_r    <= acc_r;
            out_rpm_r    <= speed_r;
            out_upd_r    <= spd_go_r;
            out_polled_r <= poll_go_r;
            out_fault_r  <= fault_r;
            out_sticky_r <= sticky_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_position_counts = out_pos_r;
  assign out_rpm_x16         = out_rpm_r;
  assign out_rpm_updated     = out_upd_r;
  assign out_polled          = out_polled_r;
  assign out_fault_now       = out_fault_r;
  assign out_fault_latched   = out_sticky_r;

  // an accepted poll always starts the load step
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD))
    else $error("accepted poll did not enter load step");

  // the divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the wait step");

  // a latched fault never returns to none
  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != FAULT_NONE) |=> (sticky_r != FAULT_NONE))
    else $error("latched fault cleared without reset");

  // faults and speed updates only come from sampled polls
  a_fault_polled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault_now != FAULT_NONE)) |-> out_polled)
    else $error("fault raised on an unsampled poll");

  a_rpm_polled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rpm_updated) |-> out_polled)
    else $error("speed updated on an unsampled poll");

endmodule
